// ===== rtl/core/cubic_bspline_curve_eval_macros.svh =====
// assertion macros used by the spline evaluator checker
`ifndef CUBIC_BSPLINE_CURVE_EVAL_MACROS_SVH
`define CUBIC_BSPLINE_CURVE_EVAL_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CBSPL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CBSPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cbspl_pkg.sv =====
// shared types and constants of the cubic b-spline evaluator
package cbspl_pkg;

    localparam int MAX_POINTS_DEF  = 256;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int REQ_TYPE_W = 2;
    localparam int INDEX_W    = 8;
    localparam int COORD_W    = 32;
    localparam int CFG_W      = 9;
    localparam int MUL_W      = 33;
    localparam int MIN_POINTS = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd4;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE       = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_EVAL_LOCAL  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_EVAL_GLOBAL = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_BAD         = 2'd3;

    // status codes
    localparam logic STS_OK    = 1'b0;
    localparam logic STS_RANGE = 1'b1;

    // saturation window of the scaled sum: 6 * 2^31
    localparam logic signed [63:0] SAT_LIM = 64'sd12884901888;
    // (12 * 2^31 - 1) >> 1, the halved offset sum at positive saturation
    localparam logic [33:0] H_MAX = 34'h2_FFFF_FFFF;

    // floor(x / 3) = (x * DIV_MAGIC) >> DIV_SHIFT for x below 2^19
    localparam logic [18:0] DIV_MAGIC = 19'd349526;
    localparam int          DIV_SHIFT = 20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SPLIT,
        S_SQ,
        S_T2,
        S_CU,
        S_T3,
        S_WGT,
        S_MAC,
        S_DRAIN,
        S_DV0,
        S_DV1,
        S_DV2,
        S_DV3,
        S_DV4,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/cbspl_if.sv =====
// request and response channel interfaces of the spline evaluator
interface cbspl_req_if #(
    parameter int TW = cbspl_pkg::T_FRAC_BITS_DEF + 1
) ();
    logic                                    valid;
    logic                                    ready;
    logic [cbspl_pkg::REQ_TYPE_W-1:0]        req_type;
    logic [cbspl_pkg::INDEX_W-1:0]           point_index;
    logic signed [cbspl_pkg::COORD_W-1:0]    point_x;
    logic signed [cbspl_pkg::COORD_W-1:0]    point_y;
    logic signed [cbspl_pkg::COORD_W-1:0]    point_z;
    logic [cbspl_pkg::INDEX_W-1:0]           segment;
    logic [TW-1:0]                           param_t;

    modport source (
        output valid, req_type, point_index, point_x, point_y, point_z, segment, param_t,
        input  ready
    );
    modport sink (
        input  valid, req_type, point_index, point_x, point_y, point_z, segment, param_t,
        output ready
    );
endinterface

interface cbspl_rsp_if ();
    logic                                    valid;
    logic                                    ready;
    logic signed [cbspl_pkg::COORD_W-1:0]    curve_x;
    logic signed [cbspl_pkg::COORD_W-1:0]    curve_y;
    logic signed [cbspl_pkg::COORD_W-1:0]    curve_z;
    logic                                    status;

    modport source (
        output valid, curve_x, curve_y, curve_z, status,
        input  ready
    );
    modport sink (
        input  valid, curve_x, curve_y, curve_z, status,
        output ready
    );
endinterface

// ===== rtl/core/cubic_bspline_curve_eval.sv =====
// cubic b-spline evaluator: point store plus one shared multiplier under a sequencer
// writes and rejected requests: result registered in the cycle after acceptance
// one such request per cycle while responses are taken; one evaluation at a time
// the single multiplier: scaling, t^2, t^3, twelve weight-point products, six divide steps
// reset (synchronous): sequencer idle, num_points back to 4; point store is not cleared
module cubic_bspline_curve_eval #(
    parameter int MAX_POINTS  = cbspl_pkg::MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = cbspl_pkg::T_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cbspl_req_if.sink                    i_req,
    cbspl_rsp_if.source                  o_rsp,
    input  logic                         i_cfg_we,
    input  logic [cbspl_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int TF    = T_FRAC_BITS;
    localparam int TW    = TF + 1;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int CW    = (NW > cbspl_pkg::CFG_W) ? NW : cbspl_pkg::CFG_W;
    localparam int WW    = TF + 4;
    localparam int ACC_W = TF + 38;
    localparam int MW    = cbspl_pkg::MUL_W;
    localparam int PW    = 2 * MW;
    localparam int RW    = 2 * TF + 2;
    localparam int CRD_W = cbspl_pkg::COORD_W;

    localparam logic [TW-1:0]          ONE_T  = {1'b1, {TF{1'b0}}};
    localparam logic [RW-1:0]          HALF_T = RW'(1) << (TF - 1);
    localparam logic signed [WW-1:0]   W_ONE  = WW'(ONE_T);
    localparam logic signed [WW-1:0]   W_3    = WW'(3);
    localparam logic signed [WW-1:0]   W_4    = WW'(4);
    localparam logic signed [WW-1:0]   W_6    = WW'(6);
    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(3) <<< TF;
    localparam logic signed [ACC_W-1:0] LIM    = ACC_W'(cbspl_pkg::SAT_LIM);

    cbspl_pkg::t_state r_state, n_state;

    logic [cbspl_pkg::CFG_W-1:0]  r_num_points;
    logic [CW-1:0]                cnt, cnt_m3, cnt_m4, cnt_ext, seg_g;
    logic [TW-1:0]                t_in;
    logic [TW-1:0]                r_t, n_t, r_t2, n_t2, r_t3, n_t3;
    logic [AW-1:0]                r_seg, n_seg, rd_addr;
    logic                         rd_en, wr_en, idx_bad, seg_bad;
    logic [3*CRD_W-1:0]           mem [MAX_POINTS];
    logic [3*CRD_W-1:0]           r_rd;
    logic signed [WW-1:0]         r_w [4];
    logic signed [WW-1:0]         n_w [4];
    logic signed [WW-1:0]         ws_t, ws_2, ws_3;
    logic [1:0]                   r_k, n_k, r_c, n_c;
    logic                         r_pv;
    logic signed [ACC_W-1:0]      r_acc0, r_acc1, r_acc2, n_acc0, n_acc1, n_acc2;
    logic signed [ACC_W-1:0]      acc_sh, acc_off;
    logic signed [MW-1:0]         mul_a, mul_b;
    logic signed [PW-1:0]         r_prod;
    logic [RW-1:0]                rnd;
    logic [33:0]                  r_h, n_h;
    logic [16:0]                  r_a, n_a, div_a, div_b, div_r;
    logic [18:0]                  r_x2, n_x2;
    logic signed [CRD_W-1:0]      r_res_x, r_res_y, r_res_z, n_res_x, n_res_y, n_res_z;
    logic                         r_out_v, n_out_v, r_out_st, n_out_st, out_free, req_ready;
    logic                         accept;
    logic signed [CRD_W-1:0]      r_out_x, r_out_y, r_out_z, n_out_x, n_out_y, n_out_z;

    // usable point count, clamped to [4, MAX_POINTS]
    always_comb begin
        cnt_ext = CW'(r_num_points);
        if (cnt_ext < CW'(cbspl_pkg::MIN_POINTS)) begin
            cnt = CW'(cbspl_pkg::MIN_POINTS);
        end else if (cnt_ext > CW'(MAX_POINTS)) begin
            cnt = CW'(MAX_POINTS);
        end else begin
            cnt = cnt_ext;
        end
        cnt_m3 = cnt - CW'(3);
        cnt_m4 = cnt - CW'(4);
    end

    assign out_free  = !r_out_v || o_rsp.ready;
    assign req_ready = (r_state == cbspl_pkg::S_IDLE) && out_free;
    assign accept    = i_req.valid && req_ready;

    assign t_in    = (i_req.param_t > ONE_T) ? ONE_T : i_req.param_t;
    assign idx_bad = (CW'(i_req.point_index) >= CW'(MAX_POINTS));
    assign seg_bad = ((CW'(i_req.segment) + CW'(3)) >= cnt);
    assign wr_en   = accept && (i_req.req_type == cbspl_pkg::REQ_WRITE) && !idx_bad;

    assign ws_t = WW'(r_t);
    assign ws_2 = WW'(r_t2);
    assign ws_3 = WW'(r_t3);

    always_comb begin
        n_state  = r_state;
        n_t      = r_t;
        n_t2     = r_t2;
        n_t3     = r_t3;
        n_seg    = r_seg;
        n_w      = r_w;
        n_k      = r_k;
        n_c      = r_c;
        n_acc0   = r_acc0;
        n_acc1   = r_acc1;
        n_acc2   = r_acc2;
        n_h      = r_h;
        n_a      = r_a;
        n_x2     = r_x2;
        n_res_x  = r_res_x;
        n_res_y  = r_res_y;
        n_res_z  = r_res_z;
        n_out_v  = r_out_v;
        n_out_st = r_out_st;
        n_out_x  = r_out_x;
        n_out_y  = r_out_y;
        n_out_z  = r_out_z;
        mul_a    = '0;
        mul_b    = '0;
        rd_en    = 1'b0;
        rd_addr  = r_seg;
        seg_g    = r_prod[TF +: CW];
        rnd      = RW'(r_prod[2*TF:0]) + HALF_T;
        acc_sh   = r_acc0 >>> TF;
        acc_off  = acc_sh + LIM;
        div_a    = r_prod[cbspl_pkg::DIV_SHIFT +: 17];
        div_b    = div_a;
        div_r    = r_h[33:17] - (div_a + {div_a[15:0], 1'b0});

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        // products land in the cycle after their multiply; the line rotates per coordinate
        if (r_pv) begin
            n_acc0 = r_acc1;
            n_acc1 = r_acc2;
            n_acc2 = r_acc0 + ACC_W'(r_prod);
        end

        unique case (r_state)
            cbspl_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_x  = '0;
                    n_out_y  = '0;
                    n_out_z  = '0;
                    n_out_st = cbspl_pkg::STS_OK;
                    n_t      = t_in;
                    n_seg    = AW'(i_req.segment);
                    case (i_req.req_type)
                        cbspl_pkg::REQ_WRITE: begin
                            n_out_v  = 1'b1;
                            n_out_st = idx_bad ? cbspl_pkg::STS_RANGE : cbspl_pkg::STS_OK;
                        end
                        cbspl_pkg::REQ_EVAL_LOCAL: begin
                            if (seg_bad) begin
                                n_out_v  = 1'b1;
                                n_out_st = cbspl_pkg::STS_RANGE;
                            end else begin
                                n_state = cbspl_pkg::S_SQ;
                            end
                        end
                        cbspl_pkg::REQ_EVAL_GLOBAL: begin
                            n_state = cbspl_pkg::S_SCALE;
                        end
                        default: begin
                            n_out_v  = 1'b1;
                            n_out_st = cbspl_pkg::STS_RANGE;
                        end
                    endcase
                end
            end
            cbspl_pkg::S_SCALE: begin
                mul_a   = MW'(r_t);
                mul_b   = MW'(cnt_m3);
                n_state = cbspl_pkg::S_SPLIT;
            end
            cbspl_pkg::S_SPLIT: begin
                // global t = 1 lands past the last segment: pin it to its end
                if (seg_g >= cnt_m3) begin
                    n_seg = AW'(cnt_m4);
                    n_t   = ONE_T;
                end else begin
                    n_seg = AW'(seg_g);
                    n_t   = {1'b0, r_prod[TF-1:0]};
                end
                n_state = cbspl_pkg::S_SQ;
            end
            cbspl_pkg::S_SQ: begin
                mul_a   = MW'(r_t);
                mul_b   = MW'(r_t);
                n_state = cbspl_pkg::S_T2;
            end
            cbspl_pkg::S_T2: begin
                n_t2    = rnd[TF +: TW];
                n_state = cbspl_pkg::S_CU;
            end
            cbspl_pkg::S_CU: begin
                mul_a   = MW'(r_t2);
                mul_b   = MW'(r_t);
                n_state = cbspl_pkg::S_T3;
            end
            cbspl_pkg::S_T3: begin
                n_t3    = rnd[TF +: TW];
                n_state = cbspl_pkg::S_WGT;
            end
            cbspl_pkg::S_WGT: begin
                n_w[0]  = W_ONE - W_3 * ws_t + W_3 * ws_2 - ws_3;
                n_w[1]  = W_3 * ws_3 - W_6 * ws_2 + W_4 * W_ONE;
                n_w[2]  = W_3 * ws_2 - W_3 * ws_3 + W_3 * ws_t + W_ONE;
                n_w[3]  = ws_3;
                n_acc0  = ACC_INIT;
                n_acc1  = ACC_INIT;
                n_acc2  = ACC_INIT;
                n_k     = 2'd0;
                n_c     = 2'd0;
                rd_en   = 1'b1;
                rd_addr = r_seg;
                n_state = cbspl_pkg::S_MAC;
            end
            cbspl_pkg::S_MAC: begin
                mul_a = MW'(r_w[r_k]);
                case (r_c)
                    2'd0:    mul_b = MW'($signed(r_rd[3*CRD_W-1:2*CRD_W]));
                    2'd1:    mul_b = MW'($signed(r_rd[2*CRD_W-1:CRD_W]));
                    default: mul_b = MW'($signed(r_rd[CRD_W-1:0]));
                endcase
                if (r_c == 2'd2) begin
                    n_c = 2'd0;
                    if (r_k == 2'd3) begin
                        n_state = cbspl_pkg::S_DRAIN;
                    end else begin
                        n_k     = r_k + 2'd1;
                        rd_en   = 1'b1;
                        rd_addr = r_seg + AW'(r_k) + AW'(1);
                    end
                end else begin
                    n_c = r_c + 2'd1;
                end
            end
            cbspl_pkg::S_DRAIN: begin
                n_state = cbspl_pkg::S_DV0;
            end
            cbspl_pkg::S_DV0: begin
                // floor(sum / 6*ONE) = floor(floor(sum / ONE) / 6), saturated window first
                if (acc_sh >= LIM) begin
                    n_h = cbspl_pkg::H_MAX;
                end else if (acc_sh < -LIM) begin
                    n_h = '0;
                end else begin
                    n_h = acc_off[34:1];
                end
                n_acc0  = r_acc1;
                n_acc1  = r_acc2;
                n_acc2  = r_acc0;
                n_state = cbspl_pkg::S_DV1;
            end
            cbspl_pkg::S_DV1: begin
                mul_a   = MW'(cbspl_pkg::DIV_MAGIC);
                mul_b   = MW'(r_h[33:17]);
                n_state = cbspl_pkg::S_DV2;
            end
            cbspl_pkg::S_DV2: begin
                n_a     = div_a;
                n_x2    = {div_r[1:0], r_h[16:0]};
                n_state = cbspl_pkg::S_DV3;
            end
            cbspl_pkg::S_DV3: begin
                mul_a   = MW'(cbspl_pkg::DIV_MAGIC);
                mul_b   = MW'(r_x2);
                n_state = cbspl_pkg::S_DV4;
            end
            cbspl_pkg::S_DV4: begin
                // quotient carries a 2^31 offset: flipping the top bit removes it
                n_res_z = {~r_a[14], r_a[13:0], div_b};
                n_res_y = r_res_z;
                n_res_x = r_res_y;
                if (r_c == 2'd2) begin
                    n_c     = 2'd0;
                    n_state = cbspl_pkg::S_DONE;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = cbspl_pkg::S_DV0;
                end
            end
            cbspl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_v  = 1'b1;
                    n_out_st = cbspl_pkg::STS_OK;
                    n_out_x  = r_res_x;
                    n_out_y  = r_res_y;
                    n_out_z  = r_res_z;
                    n_state  = cbspl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbspl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cbspl_pkg::S_IDLE;
            r_num_points <= cbspl_pkg::CFG_RESET;
            r_k          <= 2'd0;
            r_c          <= 2'd0;
            r_pv         <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_c     <= n_c;
            r_pv    <= (r_state == cbspl_pkg::S_MAC);
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                r_num_points <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_t2     <= n_t2;
        r_t3     <= n_t3;
        r_seg    <= n_seg;
        r_w      <= n_w;
        r_acc0   <= n_acc0;
        r_acc1   <= n_acc1;
        r_acc2   <= n_acc2;
        r_h      <= n_h;
        r_a      <= n_a;
        r_x2     <= n_x2;
        r_res_x  <= n_res_x;
        r_res_y  <= n_res_y;
        r_res_z  <= n_res_z;
        r_out_st <= n_out_st;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_z  <= n_out_z;
        r_prod   <= mul_a * mul_b;
    end

    // point store, x in the top third of each word
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_req.point_index)] <= {i_req.point_x, i_req.point_y, i_req.point_z};
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.status  = r_out_st;
    assign o_rsp.curve_x = r_out_x;
    assign o_rsp.curve_y = r_out_y;
    assign o_rsp.curve_z = r_out_z;

endmodule

// ===== rtl/core/cbspl_checker.sv =====
// port-level checker of the spline evaluator and its bind
module cbspl_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    input  logic                                  i_req_ready,
    input  logic [cbspl_pkg::REQ_TYPE_W-1:0]      i_req_type,
    input  logic                                  i_rsp_valid,
    input  logic                                  i_rsp_ready,
    input  logic signed [cbspl_pkg::COORD_W-1:0]  i_curve_x,
    input  logic signed [cbspl_pkg::COORD_W-1:0]  i_curve_y,
    input  logic signed [cbspl_pkg::COORD_W-1:0]  i_curve_z,
    input  logic                                  i_status
);

`include "cubic_bspline_curve_eval_macros.svh"

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    `CBSPL_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_curve_x) && $stable(i_curve_y) && $stable(i_curve_z) && $stable(i_status), "stalled response changed")
    `CBSPL_ASSERT_SAME(a_err_zero, i_rsp_valid && (i_status == cbspl_pkg::STS_RANGE), (i_curve_x == '0) && (i_curve_y == '0) && (i_curve_z == '0), "error response with nonzero point")
    `CBSPL_ASSERT_NEXT(a_global_busy, req_acc && (i_req_type == cbspl_pkg::REQ_EVAL_GLOBAL), !i_req_ready, "ready right after global request")
    `CBSPL_ASSERT_NEXT(a_write_rsp, req_acc && (i_req_type == cbspl_pkg::REQ_WRITE), i_rsp_valid, "write request without response")
    `CBSPL_ASSERT_NEXT(a_bad_req, req_acc && (i_req_type == cbspl_pkg::REQ_BAD), i_rsp_valid && (i_status == cbspl_pkg::STS_RANGE), "unknown request not flagged")

endmodule

bind cubic_bspline_curve_eval cbspl_checker u_cbspl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_curve_x   (o_rsp.curve_x),
    .i_curve_y   (o_rsp.curve_y),
    .i_curve_z   (o_rsp.curve_z),
    .i_status    (o_rsp.status)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the cubic b-spline evaluator: directed and random requests
module tb_top;
    import cbspl_pkg::*;

    localparam int     TW           = T_FRAC_BITS_DEF + 1;
    localparam longint ONE_T        = 64'd1 << T_FRAC_BITS_DEF;
    localparam longint HALF_T       = ONE_T >> 1;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     RAND_PHASES  = 6;
    localparam int     PHASE_ITEMS  = 155;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    typedef struct {
        logic [REQ_TYPE_W-1:0]     kind;
        logic [INDEX_W-1:0]        slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [INDEX_W-1:0]        seg;
        logic [TW-1:0]             t;
    } spline_req_t;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic                      sts;
    } spline_pt_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    cbspl_req_if #(.TW(TW)) req_if ();
    cbspl_rsp_if            rsp_if ();

    cubic_bspline_curve_eval dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor copy of the point store and the count register
    logic signed [COORD_W-1:0] ctrl_x [0:255];
    logic signed [COORD_W-1:0] ctrl_y [0:255];
    logic signed [COORD_W-1:0] ctrl_z [0:255];
    logic [CFG_W-1:0]          cfg_reg;

    // stimulus side bookkeeping: which slots hold data, count in effect
    bit gen_written [0:255];
    int gen_n;

    spline_req_t pend_reqs [$];
    spline_pt_t  expected_pts [$];
    spline_req_t next_req;
    spline_req_t seen_req;
    spline_pt_t  oldest;
    spline_pt_t  predicted;

    logic req_taken;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_token;
    int   hold_seen;
    int   hold_cnt;
    int   cycle_cnt;
    int   fail_cnt;
    int   n_writes, n_local, n_global, n_range, n_checked;
    int   phase_pts [RAND_PHASES] = '{256, 6, 0, 17, 511, 4};

    function automatic int usable_count(input int v);
        if (v < MIN_POINTS) return MIN_POINTS;
        if (v > MAX_POINTS_DEF) return MAX_POINTS_DEF;
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] mix_coord(
        input longint w0, input longint w1, input longint w2, input longint w3,
        input logic signed [COORD_W-1:0] p0, input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2, input logic signed [COORD_W-1:0] p3);
        longint acc;
        longint q;
        acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3 + 3 * ONE_T;
        q = acc / (6 * ONE_T);
        // floor division for negative sums
        if ((acc % (6 * ONE_T)) != 0 && acc < 0) q = q - 1;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[COORD_W-1:0];
    endfunction

    function automatic spline_pt_t blend_point(input longint base, input longint tt);
        spline_pt_t p;
        longint t2, t3, w0, w1, w2, w3;
        logic [7:0] b0, b1, b2, b3;
        t2 = (tt * tt + HALF_T) >> T_FRAC_BITS_DEF;
        t3 = (t2 * tt + HALF_T) >> T_FRAC_BITS_DEF;
        w0 = ONE_T - 3 * tt + 3 * t2 - t3;
        w1 = 3 * t3 - 6 * t2 + 4 * ONE_T;
        w2 = -3 * t3 + 3 * t2 + 3 * tt + ONE_T;
        w3 = t3;
        b0 = base[7:0];
        b1 = b0 + 8'd1;
        b2 = b0 + 8'd2;
        b3 = b0 + 8'd3;
        p.cx  = mix_coord(w0, w1, w2, w3, ctrl_x[b0], ctrl_x[b1], ctrl_x[b2], ctrl_x[b3]);
        p.cy  = mix_coord(w0, w1, w2, w3, ctrl_y[b0], ctrl_y[b1], ctrl_y[b2], ctrl_y[b3]);
        p.cz  = mix_coord(w0, w1, w2, w3, ctrl_z[b0], ctrl_z[b1], ctrl_z[b2], ctrl_z[b3]);
        p.sts = STS_OK;
        return p;
    endfunction

    // expected result of one request; writes update the store copy
    function automatic spline_pt_t eval_request(input spline_req_t r);
        spline_pt_t p;
        longint tt, g, s, frac;
        int n;
        p = '{cx: '0, cy: '0, cz: '0, sts: STS_OK};
        n = usable_count(int'(cfg_reg));
        tt = longint'(r.t);
        if (tt > ONE_T) tt = ONE_T;
        case (r.kind)
            REQ_WRITE: begin
                ctrl_x[r.slot] = r.px;
                ctrl_y[r.slot] = r.py;
                ctrl_z[r.slot] = r.pz;
            end
            REQ_EVAL_LOCAL: begin
                if (int'(r.seg) + 3 >= n) p.sts = STS_RANGE;
                else p = blend_point(longint'(r.seg), tt);
            end
            REQ_EVAL_GLOBAL: begin
                g = tt * (n - 3);
                s = g >> T_FRAC_BITS_DEF;
                frac = g & (ONE_T - 1);
                // t = 1 lands on the end of the last segment
                if (s >= n - 3) begin
                    s = n - 4;
                    frac = ONE_T;
                end
                p = blend_point(s, frac);
            end
            default: p.sts = STS_RANGE;
        endcase
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return -32'sd1;
            4, 5: return $signed(32'($urandom_range(0, 1 << 22))) - 32'sd2097152;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TW-1:0] rand_param();
        case ($urandom_range(19))
            0: return '0;
            1: return TW'(ONE_T);
            2: return TW'($urandom_range(int'(ONE_T) + 1, int'(2 * ONE_T) - 1));
            3: return TW'(1);
            4: return TW'(ONE_T - 1);
            default: return TW'($urandom_range(0, int'(ONE_T) - 1));
        endcase
    endfunction

    function automatic spline_req_t rand_fields();
        spline_req_t r;
        r.kind = REQ_WRITE;
        r.slot = $urandom;
        r.px   = rand_coord();
        r.py   = rand_coord();
        r.pz   = rand_coord();
        r.seg  = $urandom_range(0, 252);
        r.t    = rand_param();
        return r;
    endfunction

    function automatic spline_req_t mk_write(input int slot, input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
        spline_req_t r;
        r = rand_fields();
        r.kind = REQ_WRITE;
        r.slot = slot;
        r.px = x;
        r.py = y;
        r.pz = z;
        gen_written[slot] = 1'b1;
        return r;
    endfunction

    function automatic spline_req_t mk_eval(input logic [REQ_TYPE_W-1:0] kind, input int seg,
                                            input logic [TW-1:0] t);
        spline_req_t r;
        r = rand_fields();
        r.kind = kind;
        r.seg = seg;
        r.t = t;
        return r;
    endfunction

    // first slot of the four starting at s that was never written, or -1
    function automatic int first_gap(input int s);
        for (int k = 0; k < 4; k++)
            if (!gen_written[s + k]) return s + k;
        return -1;
    endfunction

    function automatic int global_seg(input logic [TW-1:0] t);
        longint tt, s;
        tt = longint'(t);
        if (tt > ONE_T) tt = ONE_T;
        s = (tt * (gen_n - 3)) >> T_FRAC_BITS_DEF;
        if (s >= gen_n - 3) s = gen_n - 4;
        return int'(s);
    endfunction

    // evaluations whose points are missing turn into the write that fills the gap
    function automatic spline_req_t next_random_item();
        spline_req_t r;
        int pick, s, gap, tries;
        r = rand_fields();
        pick = $urandom_range(99);
        if (pick < 5) begin
            r.kind = REQ_BAD;
            return r;
        end
        if (pick < 30) begin
            if ($urandom_range(1)) r.slot = $urandom_range(0, gen_n - 1);
            gen_written[r.slot] = 1'b1;
            return r;
        end
        if (pick < 65) begin
            r.kind = REQ_EVAL_LOCAL;
            if ($urandom_range(99) < 15 && gen_n <= 255) begin
                r.seg = $urandom_range(gen_n - 3, 252);
                return r;
            end
            s = $urandom_range(0, gen_n - 4);
            r.seg = s;
        end else begin
            r.kind = REQ_EVAL_GLOBAL;
            s = global_seg(r.t);
            for (tries = 0; tries < 4 && first_gap(s) >= 0; tries++) begin
                r.t = rand_param();
                s = global_seg(r.t);
            end
        end
        gap = first_gap(s);
        if (gap >= 0) begin
            r.kind = REQ_WRITE;
            r.slot = gap;
            gen_written[gap] = 1'b1;
        end
        return r;
    endfunction

    task automatic cfg_write(input int v);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        gen_n = usable_count(v);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pend_reqs.size() != 0 || req_if.valid || expected_pts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_pts.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pend_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = pend_reqs.pop_front();
                req_if.valid       <= 1'b1;
                req_if.req_type    <= next_req.kind;
                req_if.point_index <= next_req.slot;
                req_if.point_x     <= next_req.px;
                req_if.point_y     <= next_req.py;
                req_if.point_z     <= next_req.pz;
                req_if.segment     <= next_req.seg;
                req_if.param_t     <= next_req.t;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (!i_rst_n) begin
            cfg_reg = CFG_RESET;
        end else begin
            if (cfg_we) cfg_reg = cfg_wdata;
            if (req_if.valid && req_if.ready) begin
                seen_req.kind = req_if.req_type;
                seen_req.slot = req_if.point_index;
                seen_req.px   = req_if.point_x;
                seen_req.py   = req_if.point_y;
                seen_req.pz   = req_if.point_z;
                seen_req.seg  = req_if.segment;
                seen_req.t    = req_if.param_t;
                predicted = eval_request(seen_req);
                expected_pts.push_back(predicted);
                case (seen_req.kind)
                    REQ_WRITE:       n_writes++;
                    REQ_EVAL_LOCAL:  n_local++;
                    REQ_EVAL_GLOBAL: n_global++;
                    default: ;
                endcase
                if (predicted.sts == STS_RANGE) n_range++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_pts.size() == 0) begin
                    $error("result with no request pending: x=%0d y=%0d z=%0d status=%0d",
                           rsp_if.curve_x, rsp_if.curve_y, rsp_if.curve_z, rsp_if.status);
                    fail_cnt++;
                end else begin
                    oldest = expected_pts.pop_front();
                    n_checked++;
                    if (rsp_if.curve_x !== oldest.cx) begin
                        $error("curve_x: expected %0d, got %0d", oldest.cx, rsp_if.curve_x);
                        fail_cnt++;
                    end
                    if (rsp_if.curve_y !== oldest.cy) begin
                        $error("curve_y: expected %0d, got %0d", oldest.cy, rsp_if.curve_y);
                        fail_cnt++;
                    end
                    if (rsp_if.curve_z !== oldest.cz) begin
                        $error("curve_z: expected %0d, got %0d", oldest.cz, rsp_if.curve_z);
                        fail_cnt++;
                    end
                    if (rsp_if.status !== oldest.sts) begin
                        $error("status: expected %0d, got %0d", oldest.sts, rsp_if.status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        int ph;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_WRITE;
        req_if.point_index = '0;
        req_if.point_x = '0;
        req_if.point_y = '0;
        req_if.point_z = '0;
        req_if.segment = '0;
        req_if.param_t = '0;
        rsp_if.ready = 1'b0;
        req_taken = 1'b0;
        tx_idle_pct = 10;
        rx_idle_pct = 51;
        gen_n = usable_count(int'(CFG_RESET));
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset count of four points
        pend_reqs.push_back(mk_write(0, C_MAX, C_MIN, 32'sd0));
        pend_reqs.push_back(mk_write(1, C_MAX, C_MIN, -32'sd1));
        pend_reqs.push_back(mk_write(2, C_MIN, C_MAX, 32'sd1));
        pend_reqs.push_back(mk_write(3, C_MAX, C_MIN, 32'sh7FFF_0000));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, TW'(0)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, TW'(ONE_T)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, TW'(ONE_T >> 1)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, TW'(1)));
        // parameter above one is clamped
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, '1));
        // segments past the last usable one
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 1, TW'(ONE_T >> 2)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 252, TW'(ONE_T >> 2)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_GLOBAL, 0, TW'(0)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_GLOBAL, 0, TW'(ONE_T)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_GLOBAL, 0, '1));
        pend_reqs.push_back(mk_eval(REQ_EVAL_GLOBAL, 0, TW'(12345)));
        pend_reqs.push_back(mk_eval(REQ_BAD, 0, TW'(0)));
        pend_reqs.push_back(mk_write(255, C_MIN, C_MAX, -32'sd1));
        pend_reqs.push_back(mk_write(1, -32'sd1, 32'sd0, C_MAX));
        pend_reqs.push_back(mk_write(2, 32'sh0001_0000, -32'sh0001_0000, C_MIN));
        pend_reqs.push_back(mk_eval(REQ_EVAL_LOCAL, 0, TW'(ONE_T >> 2)));
        pend_reqs.push_back(mk_eval(REQ_EVAL_GLOBAL, 0, TW'(3 * (ONE_T >> 2))));
        pend_reqs.push_back(mk_eval(REQ_BAD, 252, '1));
        wait_drained();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(phase_pts[ph]);
            if (ph == 2) begin
                tx_idle_pct = 51;
                rx_idle_pct = 10;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            repeat (PHASE_ITEMS) pend_reqs.push_back(next_random_item());
            // back-pressure: results held off while requests keep coming
            if (ph == 4) hold_token++;
            wait_drained();
        end

        $display("covered %0d point writes, %0d local and %0d global evaluations",
                 n_writes, n_local, n_global);
        $display("%0d range rejects, point counts 4 to 256 incl. clamped settings, %0d results",
                 n_range, n_checked);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
